// ----- rtl/core/pfc_pkg.sv -----
package pfc_pkg;

  // Pixel format codes, shared by the source and destination selects
  localparam logic [2:0] FMT_A8       = 3'd0;
  localparam logic [2:0] FMT_RGB888   = 3'd1;
  localparam logic [2:0] FMT_RGB565   = 3'd2;
  localparam logic [2:0] FMT_RGBA5551 = 3'd3;
  localparam logic [2:0] FMT_RGBA4444 = 3'd4;
  localparam logic [2:0] FMT_RGBA8888 = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_SRC_FORMAT = 2'd0;
  localparam logic [1:0] CFG_DST_FORMAT = 2'd1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  // Canonical alpha for formats that carry none
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last;
  } out_word_t;

endpackage

// ----- rtl/core/pfc_expand.sv -----
module pfc_expand (
  input  logic [2:0]  fmt,
  input  logic [31:0] pixel,
  output logic [31:0] canon
);

  // Unpack into RGBA8888 (R byte 0 to A byte 3); low bits zero, 5551 alpha copied
  always_comb begin
    case (fmt)
      pfc_pkg::FMT_A8: begin
        canon = {pixel[7:0], 24'h000000};
      end
      pfc_pkg::FMT_RGB888: begin
        canon = {pfc_pkg::ALPHA_OPAQUE, pixel[23:0]};
      end
      pfc_pkg::FMT_RGB565: begin
        canon = {pfc_pkg::ALPHA_OPAQUE, pixel[4:0], 3'b000, pixel[10:5], 2'b00,
                 pixel[15:11], 3'b000};
      end
      pfc_pkg::FMT_RGBA5551: begin
        canon = {{8{pixel[15]}}, pixel[14:10], 3'b000, pixel[9:5], 3'b000,
                 pixel[4:0], 3'b000};
      end
      pfc_pkg::FMT_RGBA4444: begin
        canon = {pixel[3:0], 4'h0, pixel[7:4], 4'h0, pixel[11:8], 4'h0,
                 pixel[15:12], 4'h0};
      end
      pfc_pkg::FMT_RGBA8888: begin
        canon = pixel;
      end
      default: begin
        canon = 32'h0000_0000;
      end
    endcase
  end

endmodule

// ----- rtl/core/pfc_truncate.sv -----
module pfc_truncate (
  input  logic [2:0]  fmt,
  input  logic [31:0] canon,
  output logic [31:0] pixel
);

  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic [7:0] a;

  assign r = canon[7:0];
  assign g = canon[15:8];
  assign b = canon[23:16];
  assign a = canon[31:24];

  // Drop low bits into the dest layout, unused upper bits zero
  always_comb begin
    case (fmt)
      pfc_pkg::FMT_A8: begin
        pixel = {24'h000000, a};
      end
      pfc_pkg::FMT_RGB888: begin
        pixel = {8'h00, canon[23:0]};
      end
      pfc_pkg::FMT_RGB565: begin
        pixel = {16'h0000, r[7:3], g[7:2], b[7:3]};
      end
      pfc_pkg::FMT_RGBA5551: begin
        // alpha bit set when the top nibble is nonzero
        pixel = {16'h0000, (a[7:4] != 4'h0), b[7:3], g[7:3], r[7:3]};
      end
      pfc_pkg::FMT_RGBA4444: begin
        pixel = {16'h0000, r[7:4], g[7:4], b[7:4], a[7:4]};
      end
      pfc_pkg::FMT_RGBA8888: begin
        pixel = canon;
      end
      default: begin
        pixel = 32'h0000_0000;
      end
    endcase
  end

endmodule

// ----- rtl/core/pixel_format_converter.sv -----
// Pixel format converter: takes one packed pixel per word, expands it to
// RGBA8888 and repacks it in the destination format (A8, RGB888, RGB565,
// RGBA5551, RGBA4444, RGBA8888). One pixel enters per clock while in_stall is
// low; each pixel passes the input register, then the unpack/repack logic into
// the output register, from which it is offered on out_data with out_valid,
// and the flow runs at one word per clock while out_stall is low. Write
// src_format and dst_format only while no pixel is in flight; codes 6 and 7
// yield a zero pixel.
module pixel_format_converter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pfc_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pfc_pkg::out_word_t                  out_data
);

  logic [2:0]         src_format_r;
  logic [2:0]         dst_format_r;
  pfc_pkg::in_word_t  in_word_r;
  logic               in_valid_r;
  pfc_pkg::out_word_t out_word_r;
  pfc_pkg::out_word_t out_word_nxt;
  logic               out_valid_r;
  logic               adv_out;
  logic               adv_in;
  logic [31:0]        canon;
  logic [31:0]        dst_pixel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_format_r <= pfc_pkg::FMT_RGBA8888;
      dst_format_r <= pfc_pkg::FMT_RGBA8888;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfc_pkg::CFG_SRC_FORMAT: src_format_r <= cfg_wdata;
        pfc_pkg::CFG_DST_FORMAT: dst_format_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance each stage when its holder is empty or passing its word on
  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_in   = !in_valid_r || adv_out;
  assign in_stall = !adv_in;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv_in) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      in_word_r <= in_data;
    end
  end

  pfc_expand u_expand (
    .fmt   (src_format_r),
    .pixel (in_word_r.pixel),
    .canon (canon)
  );

  pfc_truncate u_truncate (
    .fmt   (dst_format_r),
    .canon (canon),
    .pixel (dst_pixel)
  );

  assign out_word_nxt.pixel = dst_pixel;
  assign out_word_nxt.last  = in_word_r.last;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && in_valid_r) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule
